>>> rtl/core/mslay_pkg.sv
// Shared types, constants and helper functions of the mip slice layout engine.
// No dependencies; every other file of the block but the checker mslay_chk imports it.
`default_nettype none
package mslay_pkg;

	localparam int unsigned MAX_LEVELS_DEF = 16;
	localparam int unsigned DW = 32;
	localparam int unsigned PADDR_W = 4;

	localparam logic [1:0] REG_UIF_PAGE  = 2'd0;
	localparam logic [1:0] REG_BLOCK_ROW = 2'd1;
	localparam logic [1:0] REG_PAGE_CACHE = 2'd2;

	localparam logic [16:0] UIF_PAGE_RST   = 17'd4096;
	localparam logic [13:0] BLOCK_ROW_RST  = 14'd1024;
	localparam logic [20:0] PAGE_CACHE_RST = 21'd32768;

	localparam logic [31:0] LEVEL0_ALIGN = 32'd4096;
	localparam logic [31:0] LAYER_ALIGN  = 32'd64;
	localparam logic [31:0] HALF_MUL     = 32'd3;

	localparam logic [2:0] TIL_RASTER   = 3'd0;
	localparam logic [2:0] TIL_LINEAR   = 3'd1;
	localparam logic [2:0] TIL_UBLINEAR1 = 3'd2;
	localparam logic [2:0] TIL_UBLINEAR2 = 3'd3;
	localparam logic [2:0] TIL_UIF      = 3'd4;
	localparam logic [2:0] TIL_UIF_XOR  = 3'd5;

	localparam logic [2:0] KIND_RASTER   = 3'd0;
	localparam logic [2:0] KIND_RASTER1D = 3'd1;
	localparam logic [2:0] KIND_RASTER3D = 3'd2;
	localparam logic [2:0] KIND_TILED    = 3'd3;
	localparam logic [2:0] KIND_TILED3D  = 3'd4;

	typedef struct packed {
		logic [16:0] uif_page;
		logic [13:0] block_row;
		logic [20:0] page_cache;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
		logic [31:0] rem;
	} div_rsp_t;

	function automatic logic [31:0] al32(input logic [31:0] x, input logic [31:0] a);
		logic [31:0] m;
		m = a - 32'd1;
		return (x + m) & ~m;
	endfunction

	function automatic logic [31:0] mini32(input logic [31:0] x, input logic [3:0] s);
		logic [31:0] r;
		r = x >> s;
		return (r == 32'd0) ? 32'd1 : r;
	endfunction

	// smallest power of two not below x, for x below 2**15
	function automatic logic [16:0] pow2up(input logic [14:0] x);
		logic [16:0] p;
		p = 17'd32768;
		for (int k = 15; k >= 0; k--) begin
			if ((17'd1 << k) >= {2'b00, x})
				p = 17'd1 << k;
		end
		return p;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/mslay_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, 32-bit operands.
// Depends on mslay_pkg for the request and response structs.
`default_nettype none
module mslay_div
	import mslay_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	always_comb begin
		shifted = {rem_q, quo_q[31]};
		diff = shifted - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= 32'd0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

>>> rtl/core/mslay_regs.sv
// APB-style configuration registers of the layout engine.
// Depends on mslay_pkg for register indexes, reset values and cfg_t.
`default_nettype none
module mslay_regs
	import mslay_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.uif_page   <= UIF_PAGE_RST;
			cfg_q.block_row  <= BLOCK_ROW_RST;
			cfg_q.page_cache <= PAGE_CACHE_RST;
		end else if (wr) begin
			case (paddr[3:2])
				REG_UIF_PAGE:   cfg_q.uif_page   <= pwdata[16:0];
				REG_BLOCK_ROW:  cfg_q.block_row  <= pwdata[13:0];
				REG_PAGE_CACHE: cfg_q.page_cache <= pwdata[20:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_UIF_PAGE:   prdata = {15'd0, cfg_q.uif_page};
			REG_BLOCK_ROW:  prdata = {18'd0, cfg_q.block_row};
			REG_PAGE_CACHE: prdata = {11'd0, cfg_q.page_cache};
			default:        prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> rtl/core/mip_slice_layout_engine_core.sv
// Top level of the mip slice layout engine: sequencer, level tables, shared multiplier.
// Depends on mslay_pkg, mslay_div and mslay_regs.
//
// One texture word is taken while in_ready is high; in_ready then stays low until the last
// level record has been taken. Levels are walked from the smallest up. Every divide goes
// through one shared radix-2 divider and holds its state until the divider is done. A level
// needs two divides plus multiplies and control; a raster one-dimensional level adds a third
// divide, and a UIF level needs six divides, or four when the page cache holds less than one
// block row. The accept and two divides for the page and cache row counts open the item, a
// final state sets the layer stride, non-3D textures add a multiply and an add for the layer
// term, and each record then passes an emit state and an output state, which it leaves when
// out_ready is high.
`default_nettype none
module mip_slice_layout_engine_core
	import mslay_pkg::*;
#(
	parameter int unsigned MAX_LEVELS = MAX_LEVELS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [14:0]        base_width,
	input  wire logic [14:0]        base_height,
	input  wire logic [11:0]        base_depth,
	input  wire logic [3:0]         top_level,
	input  wire logic [4:0]         bytes_per_pixel,
	input  wire logic [3:0]         blk_width,
	input  wire logic [3:0]         blk_height,
	input  wire logic [4:0]         utile_width,
	input  wire logic [4:0]         utile_height,
	input  wire logic               multisampled,
	input  wire logic [2:0]         layout_kind,
	input  wire logic [11:0]        layer_count,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [3:0]              level,
	output logic [2:0]              tiling,
	output logic [31:0]             level_offset,
	output logic [31:0]             row_stride,
	output logic [31:0]             padded_rows,
	output logic [31:0]             level_bytes,
	output logic [9:0]              uif_pad_rows,
	output logic [31:0]             total_bytes,
	output logic [31:0]             slice_stride,
	output logic                    last
);

	localparam int unsigned IDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam logic [3:0] TOP_MAX = 4'(MAX_LEVELS - 1);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_PR   = 5'd1;
	localparam logic [4:0] S_CR   = 5'd2;
	localparam logic [4:0] S_LV   = 5'd3;
	localparam logic [4:0] S_DW   = 5'd4;
	localparam logic [4:0] S_DH   = 5'd5;
	localparam logic [4:0] S_TIL  = 5'd6;
	localparam logic [4:0] S_K1   = 5'd7;
	localparam logic [4:0] S_HUB  = 5'd8;
	localparam logic [4:0] S_OFF  = 5'd9;
	localparam logic [4:0] S_PAD  = 5'd10;
	localparam logic [4:0] S_PM   = 5'd11;
	localparam logic [4:0] S_PA   = 5'd12;
	localparam logic [4:0] S_Q    = 5'd13;
	localparam logic [4:0] S_R    = 5'd14;
	localparam logic [4:0] S_ST   = 5'd15;
	localparam logic [4:0] S_SZ   = 5'd16;
	localparam logic [4:0] S_TOT  = 5'd17;
	localparam logic [4:0] S_LIM  = 5'd18;
	localparam logic [4:0] S_WR   = 5'd19;
	localparam logic [4:0] S_FIN  = 5'd20;
	localparam logic [4:0] S_LM   = 5'd21;
	localparam logic [4:0] S_LA   = 5'd22;
	localparam logic [4:0] S_EMIT = 5'd23;
	localparam logic [4:0] S_OUT  = 5'd24;

	cfg_t     cfg;
	div_req_t dreq;
	div_rsp_t drsp;

	mslay_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	mslay_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [4:0]  state_q;
	logic        wait_q;
	logic [3:0]  i_q, e_q, top_q;
	logic [14:0] w0_q, h0_q;
	logic [11:0] d0_q, layers_q;
	logic [4:0]  cpp_q, uw_q, uh_q;
	logic [3:0]  bw_q, bh_q;
	logic        msaa_q;
	logic [2:0]  kind_q;
	logic [31:0] pr_q, cr_q, lw_q, lh_q, ld_q, hub_q, off_q, pad_q, qt_q;
	logic [31:0] stride_q, size_q, tot_q, run_q, off0_q, pad0_q, total_q, lstride_q;
	logic [31:0] mul_q;
	logic [2:0]  til_q;

	logic [31:0] offs_m [MAX_LEVELS];
	logic [31:0] strd_m [MAX_LEVELS];
	logic [31:0] hgt_m  [MAX_LEVELS];
	logic [31:0] size_m [MAX_LEVELS];
	logic [2:0]  til_m  [MAX_LEVELS];
	logic [9:0]  pad_m  [MAX_LEVELS];

	logic [31:0] row, half, limit, uw, uh, ubw, ubh, cpp;
	logic [31:0] potw, poth, potd;
	logic [31:0] lw_b, lh_b, ld_b;
	logic [31:0] mul_a, mul_b;
	logic        tiled, is3d, small_ok, page_pad;
	logic [31:0] tot_f, run_n, pad0_n, pad_n;
	logic        div_st;

	always_comb begin
		row   = (cfg.block_row == 14'd0) ? 32'd1 : {18'd0, cfg.block_row};
		half  = (pr_q * HALF_MUL) >> 1;
		limit = cr_q - half;
		uw    = {27'd0, uw_q};
		uh    = {27'd0, uh_q};
		ubw   = uw << 1;
		ubh   = uh << 1;
		cpp   = {27'd0, cpp_q};
		tiled = (kind_q == KIND_TILED) || (kind_q == KIND_TILED3D);
		is3d  = (kind_q == KIND_RASTER3D) || (kind_q == KIND_TILED3D);
		potw  = {14'd0, pow2up(15'(mini32({17'd0, w0_q}, 4'd1))), 1'b0};
		poth  = {14'd0, pow2up(15'(mini32({17'd0, h0_q}, 4'd1))), 1'b0};
		potd  = {14'd0, pow2up(15'(mini32({20'd0, d0_q}, 4'd1))), 1'b0};
		lw_b  = (i_q < 4'd2) ? mini32({17'd0, w0_q}, i_q) : mini32(potw, i_q);
		lh_b  = (i_q < 4'd2) ? mini32({17'd0, h0_q}, i_q) : mini32(poth, i_q);
		ld_b  = (i_q == 4'd0) ? {20'd0, d0_q} : mini32(potd, i_q);
		small_ok = (i_q != 4'd0) || !msaa_q;
		page_pad = (i_q == 4'd1) && (lw_q > (ubw << 2)) && (lh_q > mul_q);
		tot_f  = page_pad ? al32(tot_q, {15'd0, cfg.uif_page}) : tot_q;
		run_n  = run_q + tot_f;
		pad0_n = al32(run_q, LEVEL0_ALIGN) - run_q;
		// bank padding from the row offset within the cache period
		if (off_q == 32'd0)
			pad_n = 32'd0;
		else if (off_q < half)
			pad_n = (hub_q < cr_q) ? 32'd0 : half - off_q;
		else if (off_q > limit)
			pad_n = cr_q - off_q;
		else
			pad_n = 32'd0;
	end

	// divider operands per state; zero-modulus steps skip the divider
	always_comb begin
		dreq.dividend = 32'd0;
		dreq.divisor  = 32'd1;
		div_st = 1'b0;
		case (state_q)
			S_PR: begin
				dreq.dividend = {15'd0, cfg.uif_page};
				dreq.divisor = row;
				div_st = 1'b1;
			end
			S_CR: begin
				dreq.dividend = {11'd0, cfg.page_cache};
				dreq.divisor = row;
				div_st = 1'b1;
			end
			S_DW: begin
				dreq.dividend = lw_q + {28'd0, bw_q} - 32'd1;
				dreq.divisor = {28'd0, bw_q};
				div_st = 1'b1;
			end
			S_DH: begin
				dreq.dividend = lh_q + {28'd0, bh_q} - 32'd1;
				dreq.divisor = {28'd0, bh_q};
				div_st = 1'b1;
			end
			S_K1: begin
				dreq.dividend = LAYER_ALIGN;
				dreq.divisor = cpp;
				div_st = 1'b1;
			end
			S_HUB, S_Q: begin
				dreq.dividend = lh_q;
				dreq.divisor = ubh;
				div_st = 1'b1;
			end
			S_OFF: begin
				dreq.dividend = hub_q;
				dreq.divisor = cr_q;
				div_st = (cr_q != 32'd0);
			end
			S_R: begin
				dreq.dividend = qt_q;
				dreq.divisor = cr_q;
				div_st = (cr_q != 32'd0);
			end
			default: ;
		endcase
		dreq.start = div_st && !wait_q;
	end

	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (state_q)
			S_PM:  begin mul_a = pad_q;     mul_b = ubh;                    end
			S_ST:  begin mul_a = lw_q;      mul_b = cpp;                    end
			S_SZ:  begin mul_a = lh_q;      mul_b = mul_q;                  end
			S_TOT: begin mul_a = mul_q;     mul_b = ld_q;                   end
			S_LIM: begin mul_a = limit;     mul_b = ubh;                    end
			S_LM:  begin mul_a = lstride_q; mul_b = {20'd0, layers_q} - 32'd1; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_WR) begin
			offs_m[i_q[IDX_W-1:0]] <= run_q;
			strd_m[i_q[IDX_W-1:0]] <= stride_q;
			hgt_m[i_q[IDX_W-1:0]]  <= lh_q;
			size_m[i_q[IDX_W-1:0]] <= size_q;
			til_m[i_q[IDX_W-1:0]]  <= til_q;
			pad_m[i_q[IDX_W-1:0]]  <= pad_q[9:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wait_q    <= 1'b0;
			out_valid <= 1'b0;
			run_q     <= 32'd0;
		end else begin
			if (dreq.start)
				wait_q <= 1'b1;
			else if (drsp.done)
				wait_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						run_q   <= 32'd0;
						state_q <= S_PR;
					end
				end
				S_PR: if (drsp.done) state_q <= S_CR;
				S_CR: if (drsp.done) state_q <= S_LV;
				S_LV: state_q <= S_DW;
				S_DW: if (drsp.done) state_q <= S_DH;
				S_DH: if (drsp.done) state_q <= S_TIL;
				S_TIL: begin
					if (!tiled)
						state_q <= (kind_q == KIND_RASTER1D) ? S_K1 : S_ST;
					else if (small_ok && ((lw_q <= uw) || (lh_q <= uh) || (lw_q <= (ubw << 1))))
						state_q <= S_ST;
					else
						state_q <= S_HUB;
				end
				S_K1:  if (drsp.done) state_q <= S_ST;
				S_HUB: if (drsp.done) state_q <= S_OFF;
				S_OFF: if (drsp.done || cr_q == 32'd0) state_q <= S_PAD;
				S_PAD: state_q <= S_PM;
				S_PM:  state_q <= S_PA;
				S_PA:  state_q <= S_Q;
				S_Q:   if (drsp.done) state_q <= S_R;
				S_R:   if (drsp.done || cr_q == 32'd0) state_q <= S_ST;
				S_ST:  state_q <= S_SZ;
				S_SZ:  state_q <= S_TOT;
				S_TOT: state_q <= S_LIM;
				S_LIM: state_q <= S_WR;
				S_WR: begin
					run_q <= run_n;
					state_q <= (i_q == 4'd0) ? S_FIN : S_LV;
				end
				S_FIN: state_q <= is3d ? S_EMIT : S_LM;
				S_LM:  state_q <= S_LA;
				S_LA:  state_q <= S_EMIT;
				S_EMIT: begin
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= (e_q == top_q) ? S_IDLE : S_EMIT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				w0_q     <= base_width;
				h0_q     <= base_height;
				d0_q     <= base_depth;
				top_q    <= (top_level > TOP_MAX) ? TOP_MAX : top_level;
				i_q      <= (top_level > TOP_MAX) ? TOP_MAX : top_level;
				cpp_q    <= (bytes_per_pixel == 5'd0) ? 5'd1 : bytes_per_pixel;
				bw_q     <= (blk_width == 4'd0) ? 4'd1 : blk_width;
				bh_q     <= (blk_height == 4'd0) ? 4'd1 : blk_height;
				uw_q     <= (utile_width == 5'd0) ? 5'd1 : utile_width;
				uh_q     <= (utile_height == 5'd0) ? 5'd1 : utile_height;
				msaa_q   <= multisampled;
				kind_q   <= (layout_kind > KIND_TILED3D) ? KIND_RASTER : layout_kind;
				layers_q <= layer_count;
			end
			S_PR: if (drsp.done) pr_q <= drsp.quot;
			S_CR: if (drsp.done) cr_q <= drsp.quot;
			S_LV: begin
				lw_q  <= msaa_q ? (lw_b << 1) : lw_b;
				lh_q  <= msaa_q ? (lh_b << 1) : lh_b;
				ld_q  <= ld_b;
				pad_q <= 32'd0;
				til_q <= TIL_RASTER;
			end
			S_DW: if (drsp.done) lw_q <= drsp.quot;
			S_DH: if (drsp.done) lh_q <= drsp.quot;
			S_TIL: begin
				if (!tiled) begin
					til_q <= TIL_RASTER;
				end else if (small_ok && ((lw_q <= uw) || (lh_q <= uh))) begin
					til_q <= TIL_LINEAR;
					lw_q  <= al32(lw_q, uw);
					lh_q  <= al32(lh_q, uh);
				end else if (small_ok && (lw_q <= ubw)) begin
					til_q <= TIL_UBLINEAR1;
					lw_q  <= al32(lw_q, ubw);
					lh_q  <= al32(lh_q, ubh);
				end else if (small_ok && (lw_q <= (ubw << 1))) begin
					til_q <= TIL_UBLINEAR2;
					lw_q  <= al32(lw_q, ubw << 1);
					lh_q  <= al32(lh_q, ubh);
				end else begin
					lw_q  <= al32(lw_q, ubw << 2);
					lh_q  <= al32(lh_q, ubh);
				end
			end
			S_K1:  if (drsp.done) lw_q <= al32(lw_q, drsp.quot);
			S_HUB: if (drsp.done) hub_q <= drsp.quot;
			S_OFF: begin
				if (cr_q == 32'd0)
					off_q <= hub_q;
				else if (drsp.done)
					off_q <= drsp.rem;
			end
			S_PAD: pad_q <= pad_n;
			S_PA:  lh_q <= lh_q + mul_q;
			S_Q:   if (drsp.done) qt_q <= drsp.quot;
			S_R: begin
				if (cr_q == 32'd0)
					til_q <= (qt_q == 32'd0) ? TIL_UIF_XOR : TIL_UIF;
				else if (drsp.done)
					til_q <= (drsp.rem == 32'd0) ? TIL_UIF_XOR : TIL_UIF;
			end
			S_SZ:  stride_q <= mul_q;
			S_TOT: size_q <= mul_q;
			S_LIM: tot_q <= mul_q;
			S_WR: begin
				if (i_q == 4'd0) begin
					off0_q  <= run_q;
					pad0_q  <= pad0_n;
					total_q <= run_n + pad0_n;
				end else begin
					i_q <= i_q - 4'd1;
				end
				e_q <= 4'd0;
			end
			S_FIN: begin
				lstride_q <= is3d ? size_q : al32(off0_q + pad0_q + size_q, LAYER_ALIGN);
			end
			S_LA: total_q <= total_q + mul_q;
			S_EMIT: begin
				level        <= e_q;
				tiling       <= til_m[e_q[IDX_W-1:0]];
				level_offset <= offs_m[e_q[IDX_W-1:0]] + pad0_q;
				row_stride   <= strd_m[e_q[IDX_W-1:0]];
				padded_rows  <= hgt_m[e_q[IDX_W-1:0]];
				level_bytes  <= size_m[e_q[IDX_W-1:0]];
				uif_pad_rows <= pad_m[e_q[IDX_W-1:0]];
				total_bytes  <= total_q;
				slice_stride <= lstride_q;
				last         <= (e_q == top_q);
			end
			S_OUT: if (out_ready && e_q != top_q) e_q <= e_q + 4'd1;
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

endmodule
`default_nettype wire

>>> rtl/core/mslay_chk.sv
// Port-level checker of the layout engine and its bind to the top level.
// Depends on mip_slice_layout_engine_core for the bind target.
`default_nettype none
module mslay_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  level,
	input wire logic [31:0] total_bytes,
	input wire logic        last
);

	// no new word while records are pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input ready while records pending");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("ready held after accept");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(level) && $stable(total_bytes)))
		else $error("stalled record changed");

	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> !out_valid) else $error("record after last");

	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> (!out_valid && !in_ready))
		else $error("block idle before last record");

endmodule

bind mip_slice_layout_engine_core mslay_chk u_chk (.*);
`default_nettype wire
